@@ hw/rtl/life_automaton_row_step_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef LIFE_AUTOMATON_ROW_STEP_MACROS_SVH
`define LIFE_AUTOMATON_ROW_STEP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LARS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define LARS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/lars_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lars_pkg;

	localparam int GRID_WIDTH = 64;
	localparam int ROW_BITS   = 64;
	localparam int WIDTH_BITS = 7;
	localparam int INDEX_BITS = 16;

	localparam logic [WIDTH_BITS-1:0] RESET_WIDTH = WIDTH_BITS'(64);

	localparam logic [3:0] BIRTH_COUNT = 4'd3;
	localparam logic [3:0] KEEP_COUNT  = 4'd2;

	// Bits a cell hands to each neighbor every cycle.
	typedef struct packed {
		logic above;
		logic held;
		logic cur;
	} nbr_t;

	typedef struct packed {
		logic [ROW_BITS-1:0]   next_cells;
		logic [INDEX_BITS-1:0] row_index;
		logic                  frame_end;
		logic                  stable;
	} res_t;

	// B3/S23 rule on the eight neighbor bits.
	function automatic logic life_rule(input logic [7:0] nb, input logic mid);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + 4'(nb[i]);
		end
		return (n == BIRTH_COUNT) || ((n == KEEP_COUNT) && mid);
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lars_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One column: holds the pending row bit and the bit above it.
module lars_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire logic          last,
	input  wire logic          active,
	input  wire logic          cell_in,
	input  wire lars_pkg::nbr_t left,
	input  wire lars_pkg::nbr_t right,
	output lars_pkg::nbr_t     side,
	output logic               nxt_a,
	output logic               nxt_b,
	output logic               chg_a,
	output logic               chg_b
);

	logic above_q;
	logic held_q;
	logic cur_m;

	assign cur_m = cell_in & active;

	assign side.above = above_q;
	assign side.held  = held_q;
	assign side.cur   = cur_m;

	// held row with above and incoming rows as neighbors
	assign nxt_a = active & lars_pkg::life_rule({left.above, above_q, right.above,
		left.held, right.held, left.cur, cur_m, right.cur}, held_q);
	// incoming bottom row, dead row below
	assign nxt_b = active & lars_pkg::life_rule({left.held, held_q, right.held,
		left.cur, right.cur, 3'b000}, cur_m);

	assign chg_a = nxt_a ^ held_q;
	assign chg_b = nxt_b ^ cur_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q <= 1'b0;
			held_q  <= 1'b0;
		end else if (load) begin
			if (last) begin
				above_q <= 1'b0;
				held_q  <= 1'b0;
			end else begin
				above_q <= held_q;
				held_q  <= cur_m;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/lars_out_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "life_automaton_row_step_macros.svh"

// Three-entry result queue; takes up to two results per cycle.
module lars_out_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [1:0]    push_n,
	input  wire lars_pkg::res_t push0,
	input  wire lars_pkg::res_t push1,
	input  wire logic          pop,
	output lars_pkg::res_t     head,
	output logic               head_valid,
	output logic               almost_full
);

	lars_pkg::res_t mem_q [3];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [1:0] wr_ptr_p1;
	logic [1:0] wr_ptr_p2;
	logic [2:0] count_q;

	function automatic logic [1:0] ptr_inc(input logic [1:0] p);
		return (p == 2'd2) ? 2'd0 : p + 2'd1;
	endfunction

	assign wr_ptr_p1   = ptr_inc(wr_ptr_q);
	assign wr_ptr_p2   = ptr_inc(wr_ptr_p1);
	assign head        = mem_q[rd_ptr_q];
	assign head_valid  = (count_q != 3'd0);
	assign almost_full = (count_q > 3'd1);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr_p1] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			case (push_n)
				2'd1:    wr_ptr_q <= wr_ptr_p1;
				2'd2:    wr_ptr_q <= wr_ptr_p2;
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + 3'(push_n) - 3'(pop);
		end
	end

	`LARS_ASSERT_NOW(a_no_overflow, clk, arst_n, push_n != 2'd0, count_q <= 3'd1, "push into a nearly full queue")
	`LARS_ASSERT_NOW(a_empty_ptrs, clk, arst_n, count_q == 3'd0, rd_ptr_q == wr_ptr_q, "empty queue with pointers apart")
	`LARS_ASSERT_NOW(a_pop_nonempty, clk, arst_n, pop, count_q != 3'd0, "pop from an empty queue")

endmodule

`default_nettype wire

@@ hw/rtl/life_automaton_row_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Row-streaming Game of Life (B3/S23) next-generation engine.
// Input channel (in_valid / in_stall): one grid row per item, top to bottom;
//   last_row marks the bottom row. Output channel (out_valid / out_stall):
//   next generation of one row per item with its row_index; the bottom row's
//   item has frame_end set and stable = 1 when nothing in the frame changed.
// A row's result is produced when the row below it is accepted; the bottom
//   row yields the pending row's item, if any, then its own. Results are
//   written into the result queue at the accepting edge.
// Throughput: one row per cycle while in_stall is low; a frame of N rows
//   yields N results, popped one at a time from the queue's single port.
// Config (cfg_valid / cfg_ready, always ready): row_width, columns at or
//   above it are dead. Takes effect on rows accepted afterwards.
// Reset: row_width = 64, no pending row, result queue empty.
// Output stall: up to three results wait in the queue; the input stalls once
//   two are waiting.
module life_automaton_row_step (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [6:0]  row_width,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] row_cells,
	input  wire logic        last_row,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      next_cells,
	output logic [15:0]      row_index,
	output logic             frame_end,
	output logic             stable
);

	logic [lars_pkg::WIDTH_BITS-1:0] row_width_q;
	logic [lars_pkg::INDEX_BITS-1:0] rows_q;
	logic                            held_valid_q;
	logic                            any_changed_q;

	logic                            accept;
	logic [lars_pkg::GRID_WIDTH-1:0] active;
	logic [lars_pkg::GRID_WIDTH-1:0] nxt_a;
	logic [lars_pkg::GRID_WIDTH-1:0] nxt_b;
	logic [lars_pkg::GRID_WIDTH-1:0] chg_a;
	logic [lars_pkg::GRID_WIDTH-1:0] chg_b;
	lars_pkg::nbr_t                  side [lars_pkg::GRID_WIDTH];
	logic                            changed_a;
	logic                            changed_b;

	lars_pkg::res_t res_a;
	lars_pkg::res_t res_b;
	lars_pkg::res_t push0;
	lars_pkg::res_t head;
	logic [1:0]     push_n;
	logic           almost_full;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid & ~in_stall;
	assign in_stall  = almost_full;

	// Row of column cells; each trades above/held/current bits with neighbors.
	for (genvar c = 0; c < lars_pkg::GRID_WIDTH; c++) begin : g_col
		lars_pkg::nbr_t left_in;
		lars_pkg::nbr_t right_in;

		assign active[c] = (row_width_q > lars_pkg::WIDTH_BITS'(c));

		if (c == 0) begin : g_left_edge
			assign left_in = '0;
		end else begin : g_left
			assign left_in = side[c-1];
		end
		if (c == lars_pkg::GRID_WIDTH - 1) begin : g_right_edge
			assign right_in = '0;
		end else begin : g_right
			assign right_in = side[c+1];
		end

		lars_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.load    (accept),
			.last    (last_row),
			.active  (active[c]),
			.cell_in (row_cells[c]),
			.left    (left_in),
			.right   (right_in),
			.side    (side[c]),
			.nxt_a   (nxt_a[c]),
			.nxt_b   (nxt_b[c]),
			.chg_a   (chg_a[c]),
			.chg_b   (chg_b[c])
		);
	end

	assign changed_a = held_valid_q & (|chg_a);
	assign changed_b = |chg_b;

	// pending row's result
	assign res_a.next_cells = lars_pkg::ROW_BITS'(nxt_a);
	assign res_a.row_index  = rows_q - lars_pkg::INDEX_BITS'(1);
	assign res_a.frame_end  = 1'b0;
	assign res_a.stable     = 1'b0;

	// bottom row's result
	assign res_b.next_cells = lars_pkg::ROW_BITS'(nxt_b);
	assign res_b.row_index  = rows_q;
	assign res_b.frame_end  = 1'b1;
	assign res_b.stable     = ~(any_changed_q | changed_a | changed_b);

	assign push0  = held_valid_q ? res_a : res_b;
	assign push_n = accept ? (2'(held_valid_q) + 2'(last_row)) : 2'd0;

	lars_out_fifo u_out_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push_n      (push_n),
		.push0       (push0),
		.push1       (res_b),
		.pop         (out_valid & ~out_stall),
		.head        (head),
		.head_valid  (out_valid),
		.almost_full (almost_full)
	);

	assign next_cells = head.next_cells;
	assign row_index  = head.row_index;
	assign frame_end  = head.frame_end;
	assign stable     = head.stable;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= lars_pkg::RESET_WIDTH;
		end else if (cfg_valid) begin
			row_width_q <= row_width;
		end
	end

	// frame bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q        <= '0;
			held_valid_q  <= 1'b0;
			any_changed_q <= 1'b0;
		end else if (accept) begin
			if (last_row) begin
				rows_q        <= '0;
				held_valid_q  <= 1'b0;
				any_changed_q <= 1'b0;
			end else begin
				rows_q        <= rows_q + lars_pkg::INDEX_BITS'(1);
				held_valid_q  <= 1'b1;
				any_changed_q <= any_changed_q | changed_a;
			end
		end
	end

	`LARS_ASSERT_NEXT(a_last_clears, clk, arst_n, accept && last_row, !held_valid_q && rows_q == '0, "frame state not cleared after bottom row")
	`LARS_ASSERT_NEXT(a_row_pending, clk, arst_n, accept && !last_row, held_valid_q, "row accepted but not pending")
	`LARS_ASSERT_NOW(a_idle_count, clk, arst_n, !held_valid_q, rows_q == '0 && !any_changed_q, "row count or change flag set with no pending row")

endmodule

`default_nettype wire
